@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the scope boundary table back end.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/msbt_pkg.sv @@
// Shared types, codes and helpers for the multicast scope boundary table.
// No dependencies; used by the front, queue, back and top-level modules.
package msbt_pkg;

  localparam int ZONE_ENTRIES_DEF = 16;
  localparam int VIF_COUNT_DEF    = 32;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_DEL      = 3'd1,
    OP_ADDR_Q   = 3'd2,
    OP_ZONE_Q   = 3'd3,
    OP_BORDER_Q = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } state_t;

  // Normalized request as it travels from front to back.
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] pfx;
    logic [5:0]  len;
    logic [15:0] vif;
    logic        vif_ok;
    logic        scoped;
  } req_t;

  // Network mask with the top len bits set; len is at most 32.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] ones;
    ones = '1;
    if (len == 6'd0) begin
      len_mask = '0;
    end else begin
      len_mask = ones << (6'd32 - len);
    end
  endfunction

endpackage

@@ rtl/core/msbt_front.sv @@
// Front end: takes requests off the input stream and normalizes them.
// Depends on msbt_pkg; feeds msbt_queue.
module msbt_front #(
  parameter int VIF_COUNT = msbt_pkg::VIF_COUNT_DEF
) (
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [55:0]      s_axis_tdata,
  input  logic [2:0]       s_axis_tuser,
  input  logic             q_ready,
  output logic             q_push,
  output msbt_pkg::req_t   q_data
);

  logic [5:0]  raw_len;
  logic [5:0]  sat_len;
  logic [31:0] addr;
  logic [15:0] vif;

  assign addr    = s_axis_tdata[31:0];
  assign raw_len = s_axis_tdata[37:32];
  assign vif     = s_axis_tdata[53:38];
  assign sat_len = (raw_len > 6'd32) ? 6'd32 : raw_len;

  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid & q_ready & ~rst;

  always_comb begin
    q_data        = '0;
    q_data.op     = msbt_pkg::op_t'(s_axis_tuser);
    q_data.addr   = addr;
    q_data.len    = sat_len;
    q_data.pfx    = addr & msbt_pkg::len_mask(sat_len);
    q_data.vif    = vif;
    // interfaces beyond the mask width never match
    q_data.vif_ok = (vif < 16'(VIF_COUNT));
    q_data.scoped = s_axis_tdata[54];
  end

endmodule

@@ rtl/core/msbt_queue.sv @@
// Two-entry request queue between the front end and the table scanner.
// Depends on msbt_pkg for the request type.
module msbt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  msbt_pkg::req_t   push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output msbt_pkg::req_t   pop_data
);

  msbt_pkg::req_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/msbt_back.sv @@
// Back end: zone table storage, one-entry-per-cycle scan, update and result register.
// Depends on msbt_pkg and assert_macros.svh; pops requests from msbt_queue.
`include "assert_macros.svh"

module msbt_back #(
  parameter int ZONE_ENTRIES = msbt_pkg::ZONE_ENTRIES_DEF,
  parameter int VIF_COUNT    = msbt_pkg::VIF_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  msbt_pkg::req_t   q_data,
  output logic             q_pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata
);

  localparam int IW     = (ZONE_ENTRIES > 1) ? $clog2(ZONE_ENTRIES) : 1;
  localparam int VIF_IW = (VIF_COUNT > 1) ? $clog2(VIF_COUNT) : 1;

  // entry storage; prefix, length and mask are only meaningful while valid
  logic [31:0]          mem_pfx  [ZONE_ENTRIES];
  logic [5:0]           mem_len  [ZONE_ENTRIES];
  logic [VIF_COUNT-1:0] mem_mask [ZONE_ENTRIES];
  logic [ZONE_ENTRIES-1:0] entry_valid;

  msbt_pkg::state_t state;
  msbt_pkg::state_t state_next;
  msbt_pkg::req_t   cur;

  logic [IW-1:0]        idx;
  logic [IW-1:0]        eval_idx;
  logic                 rd_vld;
  logic                 rd_ent_vld;
  logic [31:0]          rd_pfx;
  logic [5:0]           rd_len;
  logic [VIF_COUNT-1:0] rd_mask;

  logic                 acc_ans;
  logic                 hit_fnd;
  logic [IW-1:0]        hit_idx;
  logic [VIF_COUNT-1:0] hit_mask;
  logic                 free_fnd;
  logic [IW-1:0]        free_idx;

  logic                 out_valid;
  logic                 out_answer;
  logic                 out_full;

  logic                 load;
  logic                 out_free;
  logic                 e_hit;
  logic                 e_mbit;
  logic                 e_ans;
  logic [5:0]           shorter;
  logic [VIF_COUNT-1:0] bitvec;
  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic [VIF_COUNT-1:0] wr_mask;
  logic                 set_valid;
  logic                 clr_valid;
  logic                 add_full;

  assign out_free      = ~out_valid | m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_full, out_answer};

  // per-entry test on the registered read data
  always_comb begin
    e_hit   = rd_ent_vld && (rd_pfx == cur.pfx) && (rd_len == cur.len);
    e_mbit  = cur.vif_ok && rd_mask[cur.vif[VIF_IW-1:0]];
    shorter = (rd_len < cur.len) ? rd_len : cur.len;
    case (cur.op)
      msbt_pkg::OP_ADDR_Q:
        e_ans = ((cur.addr & msbt_pkg::len_mask(rd_len)) == rd_pfx) && e_mbit;
      msbt_pkg::OP_ZONE_Q:
        e_ans = cur.scoped && e_mbit &&
                (((rd_pfx ^ cur.pfx) & msbt_pkg::len_mask(shorter)) == 32'd0);
      msbt_pkg::OP_BORDER_Q:
        e_ans = (rd_len <= cur.len) &&
                ((cur.pfx & msbt_pkg::len_mask(rd_len)) == rd_pfx);
      default:
        e_ans = 1'b0;
    endcase
    e_ans = e_ans & rd_ent_vld;
  end

  // update decision once the scan is complete
  always_comb begin
    bitvec = '0;
    if (cur.vif_ok) begin
      bitvec[cur.vif[VIF_IW-1:0]] = 1'b1;
    end
    wr_en     = 1'b0;
    wr_idx    = hit_idx;
    wr_mask   = hit_mask | bitvec;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    add_full  = 1'b0;
    case (cur.op)
      msbt_pkg::OP_ADD: begin
        if (hit_fnd) begin
          wr_en = 1'b1;
        end else if (cur.vif_ok) begin
          if (free_fnd) begin
            wr_en     = 1'b1;
            wr_idx    = free_idx;
            wr_mask   = bitvec;
            set_valid = 1'b1;
          end else begin
            add_full = 1'b1;
          end
        end
      end
      msbt_pkg::OP_DEL: begin
        if (hit_fnd) begin
          wr_en     = 1'b1;
          wr_mask   = hit_mask & ~bitvec;
          clr_valid = (wr_mask == '0);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    case (state)
      msbt_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = msbt_pkg::ST_SCAN;
        end
      end
      msbt_pkg::ST_SCAN: begin
        if (idx == IW'(ZONE_ENTRIES - 1)) begin
          state_next = msbt_pkg::ST_DRAIN;
        end
      end
      msbt_pkg::ST_DRAIN: begin
        state_next = msbt_pkg::ST_APPLY;
      end
      msbt_pkg::ST_APPLY: begin
        // hold the update until the result register can take it
        if (out_free) begin
          load       = 1'b1;
          state_next = msbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = msbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (load && wr_en) begin
      mem_pfx[wr_idx]  <= cur.pfx;
      mem_len[wr_idx]  <= cur.len;
      mem_mask[wr_idx] <= wr_mask;
    end
    rd_pfx  <= mem_pfx[idx];
    rd_len  <= mem_len[idx];
    rd_mask <= mem_mask[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_vld <= (state == msbt_pkg::ST_SCAN);
      if (load && set_valid) begin
        entry_valid[wr_idx] <= 1'b1;
      end
      if (load && clr_valid) begin
        entry_valid[wr_idx] <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    rd_ent_vld <= entry_valid[idx];
    eval_idx   <= idx;
    if (q_pop) begin
      cur      <= q_data;
      idx      <= '0;
      acc_ans  <= 1'b0;
      hit_fnd  <= 1'b0;
      free_fnd <= 1'b0;
    end else begin
      if (state == msbt_pkg::ST_SCAN && idx != IW'(ZONE_ENTRIES - 1)) begin
        idx <= idx + IW'(1);
      end
      if (rd_vld) begin
        acc_ans <= acc_ans | e_ans;
        // keep the lowest matching and the lowest free entry
        if (e_hit && !hit_fnd) begin
          hit_fnd  <= 1'b1;
          hit_idx  <= eval_idx;
          hit_mask <= rd_mask;
        end
        if (!rd_ent_vld && !free_fnd) begin
          free_fnd <= 1'b1;
          free_idx <= eval_idx;
        end
      end
    end
    if (load) begin
      out_answer <= acc_ans;
      out_full   <= add_full;
    end
  end

  `ASSERT_IMPL(a_full_no_answer, out_valid && out_full, !out_answer, "full flagged with answer")
  `ASSERT_IMPL(a_read_from_scan, rd_vld, $past(state) == msbt_pkg::ST_SCAN, "read data outside scan")
  `ASSERT_NEXT(a_drain_to_apply, state == msbt_pkg::ST_DRAIN, state == msbt_pkg::ST_APPLY, "drain did not apply")
  `ASSERT_IMPL(a_pop_when_idle, q_pop, state == msbt_pkg::ST_IDLE && q_valid, "pop outside idle")
  `ASSERT_IMPL(a_write_on_apply, load, state == msbt_pkg::ST_APPLY && !rd_vld, "update before scan end")

endmodule

@@ rtl/core/multicast_scope_boundary_table.sv @@
// Multicast administrative scope boundary table. A request enters through the input stream
// and is normalized and queued (two slots); the back end then reads every zone entry from a
// single-port table memory, one entry per cycle, applies any add or delete, and posts one
// response. The back end takes one request at a time; its time per request is set by that
// scan of the entry memory and by any wait for the output register. The queue holds up to
// two further requests while one is in the back end, and one finished response can wait in
// the output register, so up to four requests are in flight. Opcodes: 0 add, 1 delete,
// 2 address query, 3 zone query, 4 border router query; others answer 0 and change nothing.
// Depends on msbt_pkg, msbt_front, msbt_queue and msbt_back.
module multicast_scope_boundary_table #(
  parameter int ZONE_ENTRIES = msbt_pkg::ZONE_ENTRIES_DEF,
  parameter int VIF_COUNT    = msbt_pkg::VIF_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // prefix_addr[31:0], prefix_len[37:32], vif[53:38], zone_is_scoped[54], zero[55]
  input  logic [55:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // answer[0], table_full[1], zero[7:2]
  output logic [7:0]  m_axis_tdata
);

  logic           push;
  logic           push_ready;
  msbt_pkg::req_t push_data;
  logic           pop;
  logic           pop_valid;
  msbt_pkg::req_t pop_data;

  msbt_front #(
    .VIF_COUNT (VIF_COUNT)
  ) u_front (
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready       (push_ready),
    .q_push        (push),
    .q_data        (push_data)
  );

  msbt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  msbt_back #(
    .ZONE_ENTRIES (ZONE_ENTRIES),
    .VIF_COUNT    (VIF_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (pop_valid),
    .q_data        (pop_data),
    .q_pop         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ sim/scope_table_monitor.sv @@
// Monitor for the multicast scope boundary table: watches both streams, keeps its own zone
// table, predicts one reply per request and compares it with the reply that comes out.
// Depends on msbt_pkg for the opcodes and table sizes.
module scope_table_monitor #(
  parameter int ZONE_ENTRIES = msbt_pkg::ZONE_ENTRIES_DEF,
  parameter int VIF_COUNT    = msbt_pkg::VIF_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  output int          error_count,
  output int          pending_count
);

  typedef struct packed {
    logic table_full;
    logic answer;
  } zone_reply_t;

  logic                 zone_valid  [ZONE_ENTRIES];
  logic [31:0]          zone_prefix [ZONE_ENTRIES];
  int unsigned          zone_len    [ZONE_ENTRIES];
  logic [VIF_COUNT-1:0] zone_mask   [ZONE_ENTRIES];

  zone_reply_t pending_replies [$];
  int          errors = 0;

  function automatic logic [31:0] net_mask(input int unsigned bits);
    if (bits == 0) begin
      return 32'h0;
    end
    return 32'hFFFF_FFFF << (32 - bits);
  endfunction

  // Apply one request to the zone table and return the reply it should produce.
  function automatic zone_reply_t update_zones(input logic [2:0] op, input logic [31:0] addr,
                                               input logic [5:0] len_in, input logic [15:0] vif,
                                               input logic scoped);
    int unsigned          len;
    int unsigned          shorter;
    int                   hit;
    int                   slot;
    logic [31:0]          pfx;
    logic [31:0]          m;
    logic [VIF_COUNT-1:0] vbit;
    zone_reply_t          r;
    len  = (len_in > 6'd32) ? 32 : int'(len_in);
    pfx  = addr & net_mask(len);
    vbit = '0;
    if (vif < VIF_COUNT) begin
      vbit[vif] = 1'b1;
    end
    r    = '0;
    hit  = -1;
    slot = -1;
    case (op)
      msbt_pkg::OP_ADD, msbt_pkg::OP_DEL: begin
        for (int i = 0; i < ZONE_ENTRIES; i++) begin
          if (hit < 0 && zone_valid[i] && zone_prefix[i] == pfx && zone_len[i] == len) begin
            hit = i;
          end
        end
        if (op == msbt_pkg::OP_ADD) begin
          if (hit >= 0) begin
            zone_mask[hit] |= vbit;
          end else if (vbit != '0) begin
            for (int i = 0; i < ZONE_ENTRIES; i++) begin
              if (slot < 0 && !zone_valid[i]) begin
                slot = i;
              end
            end
            if (slot < 0) begin
              r.table_full = 1'b1;
            end else begin
              zone_valid[slot]  = 1'b1;
              zone_prefix[slot] = pfx;
              zone_len[slot]    = len;
              zone_mask[slot]   = vbit;
            end
          end
        end else if (hit >= 0) begin
          // free the zone once its last boundary interface is gone
          zone_mask[hit] &= ~vbit;
          if (zone_mask[hit] == '0) begin
            zone_valid[hit] = 1'b0;
          end
        end
      end
      msbt_pkg::OP_ADDR_Q, msbt_pkg::OP_ZONE_Q, msbt_pkg::OP_BORDER_Q: begin
        for (int i = 0; i < ZONE_ENTRIES; i++) begin
          if (zone_valid[i]) begin
            m       = net_mask(zone_len[i]);
            shorter = (zone_len[i] < len) ? zone_len[i] : len;
            if (op == msbt_pkg::OP_ADDR_Q) begin
              if ((addr & m) == zone_prefix[i] && (zone_mask[i] & vbit) != '0) begin
                r.answer = 1'b1;
              end
            end else if (op == msbt_pkg::OP_ZONE_Q) begin
              if (scoped && ((zone_prefix[i] ^ pfx) & net_mask(shorter)) == 32'h0 &&
                  (zone_mask[i] & vbit) != '0) begin
                r.answer = 1'b1;
              end
            end else if (zone_len[i] <= len && (pfx & m) == zone_prefix[i]) begin
              r.answer = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    zone_reply_t want;
    zone_reply_t next_reply;
    if (rst) begin
      foreach (zone_valid[i]) begin
        zone_valid[i] = 1'b0;
      end
      pending_replies.delete();
    end else begin
      // check the reply first so that a spurious one is never matched by this cycle's request
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: reply with no request waiting: answer %0b table_full %0b",
                   $time, m_tdata[0], m_tdata[1]);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (m_tdata[0] !== want.answer) begin
            $display("%0t: answer expected %0b, got %0b", $time, want.answer, m_tdata[0]);
            errors++;
          end
          if (m_tdata[1] !== want.table_full) begin
            $display("%0t: table_full expected %0b, got %0b",
                     $time, want.table_full, m_tdata[1]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        next_reply = update_zones(s_tuser, s_tdata[31:0], s_tdata[37:32],
                                  s_tdata[53:38], s_tdata[54]);
        pending_replies = {pending_replies, next_reply};
      end
    end
    error_count   <= errors;
    pending_count <= pending_replies.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the scope boundary table bench: clock, reset, request stimulus, reply back-pressure
// and the final verdict. Depends on msbt_pkg, the table RTL and scope_table_monitor.
module testbench;

  localparam int          HALF_PERIOD  = 6;
  localparam int          RESET_CYCLES = 10;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          LONG_HOLD    = 300;
  localparam int          TAIL_CYCLES  = 60;
  localparam int          POOL_SIZE    = 24;
  localparam int          ROOT_COUNT   = 4;
  localparam int          FILL_COUNT   = 18;
  localparam int          PHASE_ITEMS  = 165;
  localparam logic [2:0]  OP_LAST_CODE = '1;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  int error_count;
  int pending_count;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;

  logic [31:0] pool_addr [POOL_SIZE];
  logic [5:0]  pool_len  [POOL_SIZE];

  always #HALF_PERIOD clk = ~clk;

  multicast_scope_boundary_table DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  scope_table_monitor monitor (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_axis_tvalid),
    .s_tready      (s_axis_tready),
    .s_tdata       (s_axis_tdata),
    .s_tuser       (s_axis_tuser),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // End the run if neither stream moves for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[multicast_scope_boundary_table] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reply side: random back-pressure, or a long hold when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [31:0] addr,
                              input logic [5:0] len, input logic [15:0] vif,
                              input logic scoped);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, scoped, vif, len, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted reply has been seen.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Mostly zones from a shared pool so adds hit, deletes free entries and queries match.
  task automatic send_random_request();
    int          pick;
    int          k;
    logic [2:0]  op;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [15:0] vif;
    logic        scoped;
    pick = $urandom_range(99);
    if (pick < 35) begin
      op = msbt_pkg::OP_ADD;
    end else if (pick < 60) begin
      op = msbt_pkg::OP_DEL;
    end else if (pick < 75) begin
      op = msbt_pkg::OP_ADDR_Q;
    end else if (pick < 85) begin
      op = msbt_pkg::OP_ZONE_Q;
    end else if (pick < 95) begin
      op = msbt_pkg::OP_BORDER_Q;
    end else begin
      op = 3'($urandom_range(msbt_pkg::OP_BORDER_Q + 1, OP_LAST_CODE));
    end
    k    = $urandom_range(POOL_SIZE - 1);
    addr = pool_addr[k];
    len  = pool_len[k];
    // set host bits below the prefix
    if (op == msbt_pkg::OP_ADDR_Q || $urandom_range(3) == 0) begin
      addr = addr ^ ($urandom >> len);
    end
    if ($urandom_range(19) == 0) begin
      addr = $urandom;
    end
    if ($urandom_range(9) == 0) begin
      len = 6'($urandom_range(63));
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      vif = 16'($urandom_range(3));
    end else if (pick < 90) begin
      vif = 16'($urandom_range(msbt_pkg::VIF_COUNT_DEF - 1));
    end else if (pick < 95) begin
      vif = 16'($urandom_range(msbt_pkg::VIF_COUNT_DEF, 2 * msbt_pkg::VIF_COUNT_DEF - 1));
    end else begin
      vif = 16'($urandom);
    end
    scoped = ($urandom_range(4) != 0);
    send_request(op, addr, len, vif, scoped);
  endtask

  // Push more new zones than the table holds, probe them, then remove them again.
  task automatic fill_and_drain();
    logic [31:0] fill_addr [FILL_COUNT];
    logic [5:0]  fill_len  [FILL_COUNT];
    logic [15:0] fill_vif  [FILL_COUNT];
    for (int i = 0; i < FILL_COUNT; i++) begin
      fill_addr[i] = $urandom;
      fill_len[i]  = 6'($urandom_range(1, 32));
      fill_vif[i]  = 16'($urandom_range(msbt_pkg::VIF_COUNT_DEF - 1));
      send_request(msbt_pkg::OP_ADD, fill_addr[i], fill_len[i], fill_vif[i], 1'b1);
    end
    for (int i = 0; i < 2; i++) begin
      send_request(msbt_pkg::OP_ADDR_Q, fill_addr[i], fill_len[i], fill_vif[i], 1'b1);
      send_request(msbt_pkg::OP_BORDER_Q, fill_addr[FILL_COUNT - 1 - i], 6'd32, fill_vif[i],
                   1'b0);
    end
    for (int i = 0; i < FILL_COUNT; i++) begin
      send_request(msbt_pkg::OP_DEL, fill_addr[i], fill_len[i], fill_vif[i], 1'b0);
    end
  endtask

  task automatic run_phase(input int in_pct, input int out_pct);
    sender_idle_pct   <= in_pct;
    receiver_idle_pct <= out_pct;
    for (int i = 0; i < PHASE_ITEMS / 2; i++) begin
      send_random_request();
    end
    fill_and_drain();
    for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++) begin
      send_random_request();
    end
    wait_drained();
  endtask

  initial begin
    logic [31:0] roots [ROOT_COUNT];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = msbt_pkg::OP_ADD;
    foreach (roots[r]) begin
      roots[r] = $urandom;
    end
    // nested prefixes under a few roots give containment and overlap
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_len[k]  = 6'($urandom_range(4, 28));
      pool_addr[k] = roots[k % ROOT_COUNT] ^ ($urandom >> pool_len[k]);
    end
    pool_len[0] = 6'd0;
    pool_len[1] = 6'd32;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct   <= 13;
    receiver_idle_pct <= 53;
    @(posedge clk);

    // directed: empty table, normalization, out-of-range interfaces, each query, frees
    send_request(msbt_pkg::OP_ADDR_Q,   32'hEF01_0203, 6'd0,  16'd0,     1'b1);
    send_request(msbt_pkg::OP_ADD,      32'hEF00_0000, 6'd8,  16'd0,     1'b0);
    send_request(msbt_pkg::OP_ADD,      32'hEF12_3456, 6'd8,  16'd31,    1'b0);
    send_request(msbt_pkg::OP_ADD,      32'hC0A8_0000, 6'd16, 16'd32,    1'b0);
    send_request(msbt_pkg::OP_ADD,      32'hEF00_0000, 6'd8,  16'hFFFF,  1'b1);
    send_request(msbt_pkg::OP_ADD,      32'hEFFF_0C22, 6'd16, 16'd5,     1'b0);
    send_request(msbt_pkg::OP_ADD,      32'hE000_0001, 6'd63, 16'd1,     1'b0);
    send_request(msbt_pkg::OP_ADD,      32'hFFFF_FFFF, 6'd0,  16'd2,     1'b0);
    send_request(msbt_pkg::OP_ADDR_Q,   32'hEF01_0203, 6'd63, 16'd31,    1'b0);
    send_request(msbt_pkg::OP_ADDR_Q,   32'hEF01_0203, 6'd8,  16'd32,    1'b0);
    send_request(msbt_pkg::OP_ADDR_Q,   32'h0A00_0001, 6'd0,  16'd2,     1'b0);
    send_request(msbt_pkg::OP_ZONE_Q,   32'hE000_0000, 6'd4,  16'd5,     1'b1);
    send_request(msbt_pkg::OP_ZONE_Q,   32'hE000_0000, 6'd4,  16'd5,     1'b0);
    send_request(msbt_pkg::OP_ZONE_Q,   32'hC0A8_0000, 6'd16, 16'd31,    1'b1);
    send_request(msbt_pkg::OP_BORDER_Q, 32'hEF01_0000, 6'd16, 16'd0,     1'b0);
    send_request(msbt_pkg::OP_BORDER_Q, 32'hE000_0000, 6'd4,  16'd0,     1'b0);
    send_request(msbt_pkg::OP_DEL,      32'hC0A8_0000, 6'd16, 16'd0,     1'b0);
    send_request(msbt_pkg::OP_DEL,      32'hEF00_0000, 6'd8,  16'd0,     1'b0);
    send_request(msbt_pkg::OP_DEL,      32'hEF00_0000, 6'd8,  16'd31,    1'b0);
    send_request(msbt_pkg::OP_ADDR_Q,   32'hEF01_0203, 6'd8,  16'd31,    1'b0);
    send_request(msbt_pkg::OP_DEL,      32'hFFFF_FFFF, 6'd0,  16'd2,     1'b0);
    send_request(msbt_pkg::OP_BORDER_Q, 32'hE000_0000, 6'd4,  16'd0,     1'b0);
    for (int c = msbt_pkg::OP_BORDER_Q + 1; c <= OP_LAST_CODE; c++) begin
      send_request(3'(c), $urandom, 6'($urandom), 16'($urandom), 1'($urandom));
    end
    wait_drained();

    run_phase(13, 53);
    run_phase(53, 13);
    run_phase(0, 0);

    // hold the reply side while requests keep coming so the input stalls
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 24; i++) begin
      send_random_request();
    end
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[multicast_scope_boundary_table] OK");
    end else begin
      $display("[multicast_scope_boundary_table] ERROR");
    end
    $finish;
  end

endmodule
